// ===== design/drek_pkg.sv =====
// Shared types, codes and constants of the dual rotary encoder keypad unit.
package drek_pkg;

  // Configuration port widths and register indexes
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_CONTACT_DEBOUNCE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_DEBOUNCE  = 4'd1;
  localparam logic [CFG_DATA_W-1:0]  CONTACT_DEBOUNCE_RESET = 16'd1000;
  localparam logic [CFG_DATA_W-1:0]  BUTTON_DEBOUNCE_RESET  = 16'd5000;

  // Stream widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int NUM_KNOBS  = 4;
  localparam int NUM_PUSH   = 2;

  // HID codes
  localparam logic [7:0] KEY_NONE        = 8'h00;
  localparam logic [7:0] KEY_MAIN_LEFT   = 8'h04;
  localparam logic [7:0] KEY_MAIN_RIGHT  = 8'h05;
  localparam logic [7:0] KEY_BUTTON      = 8'h06;
  localparam logic [7:0] KEY_SEC_LEFT    = 8'h07;
  localparam logic [7:0] KEY_SEC_RIGHT   = 8'h08;
  localparam logic [7:0] MOD_NONE        = 8'h00;
  localparam logic [7:0] MOD_ENCODER1    = 8'h02;

  // Latched knob click
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_LEFT  = 2'd1,
    PEND_RIGHT = 2'd2
  } knob_pend_t;

  // Knob decoder phase
  typedef enum logic [4:0] {
    KNOB_IDLE  = 5'b00001,
    KNOB_DEB0  = 5'b00010,
    KNOB_WAIT1 = 5'b00100,
    KNOB_DEB1  = 5'b01000,
    KNOB_WAIT0 = 5'b10000
  } knob_phase_t;

  // Push button debounce phase
  typedef enum logic [1:0] {
    PUSH_IDLE = 2'b01,
    PUSH_DEB  = 2'b10
  } push_phase_t;

  // Pending events of all lanes after the current tick
  typedef struct packed {
    knob_pend_t [NUM_KNOBS-1:0] knob;
    logic [NUM_PUSH-1:0]        push;
  } pend_set_t;

endpackage

// ===== design/drek_knob_lane.sv =====
// One quadrature knob lane: contact levels, debounce timer and click latch.
module drek_knob_lane #(
  parameter int TIMER_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       prime,
  input  logic                       clr,
  input  logic                       c0,
  input  logic                       c1,
  input  logic [TIMER_BITS-1:0]      load,
  output drek_pkg::knob_pend_t       pend_next
);

  drek_pkg::knob_phase_t phase, phase_next;
  logic [TIMER_BITS-1:0] timer, timer_next;
  drek_pkg::knob_pend_t  pend;
  logic                  lvl0, lvl1, lvl0_next, lvl1_next;
  logic                  lv0, lv1;

  // Take the first sample as the reference levels
  assign lv0 = prime ? c0 : lvl0;
  assign lv1 = prime ? c1 : lvl1;

  // Advance the decoder by one tick
  always_comb begin
    phase_next = phase;
    timer_next = timer;
    pend_next  = pend;
    lvl0_next  = lv0;
    lvl1_next  = lv1;
    case (phase)
      drek_pkg::KNOB_IDLE: begin
        if (c0 != lv0) begin
          phase_next = drek_pkg::KNOB_DEB0;
          timer_next = load;
        end else if (c1 != lv1) begin
          phase_next = drek_pkg::KNOB_DEB1;
          timer_next = load;
        end
      end
      drek_pkg::KNOB_DEB0: begin
        if (timer != '0) begin
          timer_next = timer - TIMER_BITS'(1);
        end else if (c0 != lv0) begin
          lvl0_next  = c0;
          phase_next = drek_pkg::KNOB_WAIT1;
        end else begin
          phase_next = drek_pkg::KNOB_IDLE;
        end
      end
      drek_pkg::KNOB_WAIT1: begin
        if (c1 != lv1) begin
          lvl1_next  = c1;
          pend_next  = drek_pkg::PEND_LEFT;
          phase_next = drek_pkg::KNOB_IDLE;
        end
      end
      drek_pkg::KNOB_DEB1: begin
        if (timer != '0) begin
          timer_next = timer - TIMER_BITS'(1);
        end else if (c1 != lv1) begin
          lvl1_next  = c1;
          phase_next = drek_pkg::KNOB_WAIT0;
        end else begin
          phase_next = drek_pkg::KNOB_IDLE;
        end
      end
      drek_pkg::KNOB_WAIT0: begin
        if (c0 != lv0) begin
          lvl0_next  = c0;
          pend_next  = drek_pkg::PEND_RIGHT;
          phase_next = drek_pkg::KNOB_IDLE;
        end
      end
      default: begin
        phase_next = drek_pkg::KNOB_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= drek_pkg::KNOB_IDLE;
      timer <= '0;
      pend  <= drek_pkg::PEND_NONE;
    end else if (adv) begin
      phase <= phase_next;
      timer <= timer_next;
      pend  <= clr ? drek_pkg::PEND_NONE : pend_next;
    end
  end

  // Contact levels, valid once primed
  always_ff @(posedge clk) begin
    if (adv) begin
      lvl0 <= lvl0_next;
      lvl1 <= lvl1_next;
    end
  end

endmodule

// ===== design/drek_push_lane.sv =====
// One push button lane: debounce timer and press latch.
module drek_push_lane #(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  clr,
  input  logic                  level,
  input  logic [TIMER_BITS-1:0] load,
  output logic                  pend_next
);

  drek_pkg::push_phase_t phase, phase_next;
  logic [TIMER_BITS-1:0] timer, timer_next;
  logic                  pend;

  // Advance the debounce by one tick
  always_comb begin
    phase_next = phase;
    timer_next = timer;
    pend_next  = pend;
    case (phase)
      drek_pkg::PUSH_IDLE: begin
        if (level) begin
          phase_next = drek_pkg::PUSH_DEB;
          timer_next = load;
        end
      end
      drek_pkg::PUSH_DEB: begin
        if (timer != '0) begin
          timer_next = timer - TIMER_BITS'(1);
        end else begin
          if (level) begin
            pend_next = 1'b1;
          end
          phase_next = drek_pkg::PUSH_IDLE;
        end
      end
      default: begin
        phase_next = drek_pkg::PUSH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= drek_pkg::PUSH_IDLE;
      timer <= '0;
      pend  <= 1'b0;
    end else if (adv) begin
      phase <= phase_next;
      timer <= timer_next;
      pend  <= clr ? 1'b0 : pend_next;
    end
  end

endmodule

// ===== design/drek_report_merge.sv =====
// Merge stage: picks the HID modifier and key from the pending events of all lanes.
module drek_report_merge (
  input  drek_pkg::pend_set_t pend,
  output logic [7:0]          modifier,
  output logic [7:0]          keycode
);

  logic [7:0] key [drek_pkg::NUM_PUSH];
  logic       any [drek_pkg::NUM_PUSH];

  // Per encoder: button over secondary knob over main knob
  always_comb begin
    for (int e = 0; e < drek_pkg::NUM_PUSH; e++) begin
      key[e] = drek_pkg::KEY_NONE;
      any[e] = 1'b1;
      if (pend.push[e]) begin
        key[e] = drek_pkg::KEY_BUTTON;
      end else if (pend.knob[2*e+1] == drek_pkg::PEND_RIGHT) begin
        key[e] = drek_pkg::KEY_SEC_RIGHT;
      end else if (pend.knob[2*e+1] == drek_pkg::PEND_LEFT) begin
        key[e] = drek_pkg::KEY_SEC_LEFT;
      end else if (pend.knob[2*e] == drek_pkg::PEND_RIGHT) begin
        key[e] = drek_pkg::KEY_MAIN_RIGHT;
      end else if (pend.knob[2*e] == drek_pkg::PEND_LEFT) begin
        key[e] = drek_pkg::KEY_MAIN_LEFT;
      end else begin
        any[e] = 1'b0;
      end
    end
  end

  // Encoder 2 wins the key; modifier flags any encoder 1 event
  assign keycode  = any[1] ? key[1] : key[0];
  assign modifier = any[0] ? drek_pkg::MOD_ENCODER1 : drek_pkg::MOD_NONE;

endmodule

// ===== design/dual_rotary_encoder_keypad_unit.sv =====
// Top level of the dual rotary encoder keypad unit: lanes, merge and output register.
// Each input item is one sample tick of both encoders' pins; four knob lanes and two
// button lanes update side by side in the cycle the item is accepted, and the merge
// stage forms the report, which is registered on the output. One item is taken per
// clock unless stalled; an item with report_ready set yields one result item on the
// next cycle. The output register holds one result, so a stalled output also stalls
// the input. Debounce waits of D ticks recheck the contact D+1 ticks after a change;
// values above the timer range saturate. There is no clearing pass after reset.
module dual_rotary_encoder_keypad_unit #(
  parameter int TIMER_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Sample items
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [0] e1_knob1_contact0 [1] e1_knob1_contact1 [2] e1_knob2_contact0
  // [3] e1_knob2_contact1 [4] e1_push [5] e2_knob1_contact0 [6] e2_knob1_contact1
  // [7] e2_knob2_contact0 [8] e2_knob2_contact1 [9] e2_push [10] report_ready
  input  logic [drek_pkg::IN_DATA_W-1:0]      s_tdata,
  // Report items
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] modifier [15:8] keycode
  output logic [drek_pkg::OUT_DATA_W-1:0]     m_tdata,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [drek_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [drek_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  logic [drek_pkg::CFG_DATA_W-1:0] contact_debounce, button_debounce;
  logic [TIMER_BITS-1:0]           contact_load, button_load;
  logic                            primed, adv, report;
  logic [7:0]                      modifier, keycode;
  drek_pkg::pend_set_t             pend_next;
  logic [7:0]                      knob_c;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign adv       = s_tvalid && s_tready;
  assign report    = s_tdata[10];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      contact_debounce <= drek_pkg::CONTACT_DEBOUNCE_RESET;
      button_debounce  <= drek_pkg::BUTTON_DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == drek_pkg::REG_CONTACT_DEBOUNCE) begin
        contact_debounce <= cfg_data;
      end else if (cfg_index == drek_pkg::REG_BUTTON_DEBOUNCE) begin
        button_debounce <= cfg_data;
      end
    end
  end

  // Saturate the timer load values to the timer range
  assign contact_load = (32'(contact_debounce) > TIMER_MAX) ?
                        TIMER_BITS'(TIMER_MAX) : TIMER_BITS'(32'(contact_debounce));
  assign button_load  = (32'(button_debounce) > TIMER_MAX) ?
                        TIMER_BITS'(TIMER_MAX) : TIMER_BITS'(32'(button_debounce));

  // Capture contact levels from the first sample
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (adv) begin
      primed <= 1'b1;
    end
  end

  // Contacts in knob order: e1 main, e1 secondary, e2 main, e2 secondary
  assign knob_c = {s_tdata[8:5], s_tdata[3:0]};

  for (genvar k = 0; k < drek_pkg::NUM_KNOBS; k++) begin : g_knob
    drek_knob_lane #(.TIMER_BITS(TIMER_BITS)) u_knob (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .prime     (!primed),
      .clr       (report),
      .c0        (knob_c[2*k]),
      .c1        (knob_c[2*k+1]),
      .load      (contact_load),
      .pend_next (pend_next.knob[k])
    );
  end

  for (genvar b = 0; b < drek_pkg::NUM_PUSH; b++) begin : g_push
    drek_push_lane #(.TIMER_BITS(TIMER_BITS)) u_push (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .clr       (report),
      .level     (s_tdata[5*b+4]),
      .load      (button_load),
      .pend_next (pend_next.push[b])
    );
  end

  drek_report_merge u_merge (
    .pend     (pend_next),
    .modifier (modifier),
    .keycode  (keycode)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= report;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && report) begin
      m_tdata <= {keycode, modifier};
    end
  end

endmodule

// ===== design/drek_checker.sv =====
// Port-level checker for the dual rotary encoder keypad unit, bound to the top level.
module drek_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [drek_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [drek_pkg::OUT_DATA_W-1:0] m_tdata
);

  // An accepted report request yields a result item on the next cycle
  a_report_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[10] |=> m_tvalid)
    else $error("report request produced no result item");

  // A stalled result item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result item changed");

  // The input stalls only behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a waiting result");

  // Key is none or one of the event keys
  a_key_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:8] == drek_pkg::KEY_NONE ||
                 m_tdata[15:8] == drek_pkg::KEY_MAIN_LEFT ||
                 m_tdata[15:8] == drek_pkg::KEY_MAIN_RIGHT ||
                 m_tdata[15:8] == drek_pkg::KEY_BUTTON ||
                 m_tdata[15:8] == drek_pkg::KEY_SEC_LEFT ||
                 m_tdata[15:8] == drek_pkg::KEY_SEC_RIGHT)
    else $error("illegal keycode");

  // An encoder 1 modifier always comes with a key
  a_mod_key: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] == drek_pkg::MOD_NONE) ||
                 (m_tdata[7:0] == drek_pkg::MOD_ENCODER1 &&
                  m_tdata[15:8] != drek_pkg::KEY_NONE))
    else $error("modifier without key or illegal modifier");

endmodule

bind dual_rotary_encoder_keypad_unit drek_checker u_drek_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/dual_rotary_encoder_keypad_unit_tb.sv =====
// Self-checking testbench of the dual rotary encoder keypad unit with a report predictor.
module dual_rotary_encoder_keypad_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 400;
  localparam int MAX_NOTES  = 40;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             s_tvalid  = 1'b0;
  logic [drek_pkg::IN_DATA_W-1:0]   s_tdata   = '0;
  logic                             m_tready  = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic [drek_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [drek_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                             s_tready;
  logic                             m_tvalid;
  logic [drek_pkg::OUT_DATA_W-1:0]  m_tdata;
  logic                             cfg_ready;

  dual_rotary_encoder_keypad_unit #(
    .TIMER_BITS(16)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow of the keypad state: predicts each HID report and checks the ones that come out
  class keypad_shadow;
    logic [15:0]           contact_deb;
    logic [15:0]           button_deb;
    logic [7:0]            level;
    bit                    primed;
    drek_pkg::knob_phase_t kphase[4];
    logic [15:0]           ktimer[4];
    drek_pkg::knob_pend_t  kpend[4];
    drek_pkg::push_phase_t pphase[2];
    logic [15:0]           ptimer[2];
    bit                    ppend[2];
    logic [15:0]           due_reports[$];
    int                    errors;

    function new();
      contact_deb = drek_pkg::CONTACT_DEBOUNCE_RESET;
      button_deb  = drek_pkg::BUTTON_DEBOUNCE_RESET;
      level  = '0;
      primed = 1'b0;
      errors = 0;
      for (int i = 0; i < 4; i++) begin
        kphase[i] = drek_pkg::KNOB_IDLE;
        ktimer[i] = '0;
        kpend[i]  = drek_pkg::PEND_NONE;
      end
      for (int i = 0; i < 2; i++) begin
        pphase[i] = drek_pkg::PUSH_IDLE;
        ptimer[i] = '0;
        ppend[i]  = 1'b0;
      end
    endfunction

    function void set_reg(logic [drek_pkg::CFG_INDEX_W-1:0] idx,
                          logic [drek_pkg::CFG_DATA_W-1:0] val);
      if (idx == drek_pkg::REG_CONTACT_DEBOUNCE) contact_deb = val;
      else if (idx == drek_pkg::REG_BUTTON_DEBOUNCE) button_deb = val;
    endfunction

    // Advance one knob decoder by one tick
    function void step_knob(int k, bit c0, bit c1);
      int i0;
      int i1;
      i0 = 2 * k;
      i1 = i0 + 1;
      case (kphase[k])
        drek_pkg::KNOB_IDLE: begin
          if (c0 != level[i0]) begin
            kphase[k] = drek_pkg::KNOB_DEB0;
            ktimer[k] = contact_deb;
          end else if (c1 != level[i1]) begin
            kphase[k] = drek_pkg::KNOB_DEB1;
            ktimer[k] = contact_deb;
          end
        end
        drek_pkg::KNOB_DEB0: begin
          if (ktimer[k] != 0) ktimer[k] = ktimer[k] - 1'b1;
          else if (c0 != level[i0]) begin
            level[i0] = c0;
            kphase[k] = drek_pkg::KNOB_WAIT1;
          end else kphase[k] = drek_pkg::KNOB_IDLE;
        end
        drek_pkg::KNOB_WAIT1: begin
          if (c1 != level[i1]) begin
            level[i1] = c1;
            kpend[k]  = drek_pkg::PEND_LEFT;
            kphase[k] = drek_pkg::KNOB_IDLE;
          end
        end
        drek_pkg::KNOB_DEB1: begin
          if (ktimer[k] != 0) ktimer[k] = ktimer[k] - 1'b1;
          else if (c1 != level[i1]) begin
            level[i1] = c1;
            kphase[k] = drek_pkg::KNOB_WAIT0;
          end else kphase[k] = drek_pkg::KNOB_IDLE;
        end
        drek_pkg::KNOB_WAIT0: begin
          if (c0 != level[i0]) begin
            level[i0] = c0;
            kpend[k]  = drek_pkg::PEND_RIGHT;
            kphase[k] = drek_pkg::KNOB_IDLE;
          end
        end
        default: kphase[k] = drek_pkg::KNOB_IDLE;
      endcase
    endfunction

    // Advance one button debouncer; a held button relatches after each wait
    function void step_push(int b, bit lvl);
      if (pphase[b] == drek_pkg::PUSH_IDLE) begin
        if (lvl) begin
          pphase[b] = drek_pkg::PUSH_DEB;
          ptimer[b] = button_deb;
        end
      end else if (ptimer[b] != 0) begin
        ptimer[b] = ptimer[b] - 1'b1;
      end else begin
        if (lvl) ppend[b] = 1'b1;
        pphase[b] = drek_pkg::PUSH_IDLE;
      end
    endfunction

    // Highest-priority key of one encoder: button, then secondary knob, then main knob
    function logic [7:0] encoder_key(int e, output bit any);
      logic [7:0] key;
      key = drek_pkg::KEY_NONE;
      any = 1'b0;
      if (kpend[2*e] == drek_pkg::PEND_LEFT) begin
        key = drek_pkg::KEY_MAIN_LEFT; any = 1'b1;
      end
      if (kpend[2*e] == drek_pkg::PEND_RIGHT) begin
        key = drek_pkg::KEY_MAIN_RIGHT; any = 1'b1;
      end
      if (kpend[2*e+1] == drek_pkg::PEND_LEFT) begin
        key = drek_pkg::KEY_SEC_LEFT; any = 1'b1;
      end
      if (kpend[2*e+1] == drek_pkg::PEND_RIGHT) begin
        key = drek_pkg::KEY_SEC_RIGHT; any = 1'b1;
      end
      if (ppend[e]) begin
        key = drek_pkg::KEY_BUTTON; any = 1'b1;
      end
      return key;
    endfunction

    // Apply one accepted sample tick; queue a report when the host is ready
    function void take_sample(logic [10:0] d);
      bit [7:0]   c;
      bit         any1;
      bit         any2;
      logic [7:0] key1;
      logic [7:0] key2;
      c = {d[8:5], d[3:0]};
      if (!primed) begin
        level  = c;
        primed = 1'b1;
      end
      for (int k = 0; k < 4; k++) step_knob(k, c[2*k], c[2*k+1]);
      step_push(0, d[4]);
      step_push(1, d[9]);
      if (d[10]) begin
        key1 = encoder_key(0, any1);
        key2 = encoder_key(1, any2);
        due_reports.push_back({any2 ? key2 : key1,
                               any1 ? drek_pkg::MOD_ENCODER1 : drek_pkg::MOD_NONE});
        for (int k = 0; k < 4; k++) kpend[k] = drek_pkg::PEND_NONE;
        ppend[0] = 1'b0;
        ppend[1] = 1'b0;
      end
    endfunction

    // Compare one report item against the oldest prediction
    function void match_report(logic [15:0] got);
      logic [15:0] want;
      if (due_reports.size() == 0) begin
        if (errors < MAX_NOTES)
          $display("%0t: unexpected report expected none got %h", $time, got);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      if (got[7:0] !== want[7:0]) begin
        if (errors < MAX_NOTES)
          $display("%0t: modifier expected %h got %h", $time, want[7:0], got[7:0]);
        errors++;
      end
      if (got[15:8] !== want[15:8]) begin
        if (errors < MAX_NOTES)
          $display("%0t: keycode expected %h got %h", $time, want[15:8], got[15:8]);
        errors++;
      end
    endfunction
  endclass

  keypad_shadow shadow;
  bit           calm         = 1'b0;
  bit           held_once    = 1'b0;
  int           reports_seen = 0;
  int           stall_cycles = 0;

  // Pin generator state
  logic [9:0]   pins = '0;
  int           knob_wait[4];
  int           knob_step[4];
  int           knob_first[4];
  int           push_wait[2];

  always #10 clk = ~clk;

  // Check each report item as it leaves
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      shadow.match_report(m_tdata);
      reports_seen++;
    end
  end

  // Watchdog: count cycles in which no item moves on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IDLE_LIMIT) begin
      $display("FAIL dual_rotary_encoder_keypad_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Report receiver: random stalls, one long hold-off, none in the calm part
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && !held_once && reports_seen >= 120) begin
        m_tready <= 1'b0;
        held_once = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  function automatic int pin_of(input int k, input int j);
    return (k < 2) ? 2 * k + j : 2 * k + 1 + j;
  endfunction

  task automatic write_reg(input logic [drek_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [drek_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_reg(idx, val);
  endtask

  task automatic program_regs(input logic [15:0] contact_val, input logic [15:0] button_val);
    write_reg(drek_pkg::REG_CONTACT_DEBOUNCE, contact_val);
    write_reg(drek_pkg::REG_BUTTON_DEBOUNCE, button_val);
    cfg_valid <= 1'b0;
  endtask

  // Offer one sample item, hold until accepted, then maybe idle for a burst
  task automatic send_sample(input logic [10:0] d);
    s_tdata  <= {5'b0, d};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    shadow.take_sample(d);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stop offering, wait for all predicted reports, then let the lanes settle
  task automatic drain(input int extra);
    s_tvalid <= 1'b0;
    while (shadow.due_reports.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Mostly well-formed knob turns and button presses, plus glitches and pin noise
  task automatic run_random(input int count);
    int span_c;
    int span_b;
    int r;
    int j;
    span_c = (shadow.contact_deb > 24) ? 24 : int'(shadow.contact_deb);
    span_b = (shadow.button_deb > 30) ? 30 : int'(shadow.button_deb);
    repeat (count) begin
      for (int k = 0; k < 4; k++) begin
        if (knob_wait[k] > 0) begin
          knob_wait[k]--;
        end else if (knob_step[k] != 0) begin
          // finish the turn with the other contact, or bounce back the same one
          j = (knob_step[k] == 1) ? 1 - knob_first[k] : knob_first[k];
          pins[pin_of(k, j)] = ~pins[pin_of(k, j)];
          knob_step[k] = 0;
          knob_wait[k] = $urandom_range(0, 6);
        end else if ($urandom_range(0, 3) == 0) begin
          r = $urandom_range(0, 15);
          knob_first[k] = r % 2;
          if (r == 0) begin
            // both contacts flip together
            pins[pin_of(k, 0)] = ~pins[pin_of(k, 0)];
            pins[pin_of(k, 1)] = ~pins[pin_of(k, 1)];
            knob_wait[k] = $urandom_range(0, span_c + 3);
          end else begin
            pins[pin_of(k, knob_first[k])] = ~pins[pin_of(k, knob_first[k])];
            knob_step[k] = (r < 3) ? 2 : 1;
            knob_wait[k] = (r < 3) ? $urandom_range(0, span_c) :
                                     $urandom_range(span_c / 2, span_c + 3);
          end
        end
      end
      for (int b = 0; b < 2; b++) begin
        if (push_wait[b] > 0) begin
          push_wait[b]--;
        end else begin
          pins[b ? 9 : 4] = ~pins[b ? 9 : 4];
          push_wait[b] = $urandom_range(0, 2 * span_b + 2);
        end
      end
      if ($urandom_range(0, 31) == 0) begin
        j = $urandom_range(0, 9);
        pins[j] = ~pins[j];
      end
      send_sample({($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0, pins});
    end
  endtask

  // Opening items with zero debounce: first-sample capture, left and right turns,
  // both contacts at once, button press and relatch, encoder priority, a rejected
  // glitch, and all-ones and all-zeros pins
  logic [10:0] opening [23] = '{
    11'h4A3, 11'h0A2, 11'h0A2, 11'h0A0, 11'h4A0, 11'h1A0, 11'h1A0, 11'h120,
    11'h530, 11'h130, 11'h530, 11'h130, 11'h13C, 11'h13C, 11'h13C, 11'h33C,
    11'h73C, 11'h10C, 11'h12C, 11'h52C, 11'h7FF, 11'h000, 11'h400
  };

  initial begin
    shadow = new();
    for (int k = 0; k < 4; k++) begin
      knob_wait[k]  = 0;
      knob_step[k]  = 0;
      knob_first[k] = 0;
    end
    push_wait[0] = 0;
    push_wait[1] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    program_regs(16'd0, 16'd0);
    foreach (opening[i]) send_sample(opening[i]);
    pins = opening[22][9:0];
    run_random(300);

    drain(4);
    program_regs(16'd1, 16'd3);
    run_random(350);

    drain(4);
    program_regs(16'd4, 16'd0);
    run_random(300);

    drain(4);
    program_regs(16'd0, 16'd7);
    run_random(300);

    drain(4);
    program_regs(16'd12, 16'd20);
    run_random(350);

    // calm part: no idling on either side
    drain(4);
    calm = 1'b1;
    program_regs(16'd2, 16'd5);
    run_random(200);

    drain(4);
    program_regs(16'hFFFF, 16'hFFFF);
    run_random(150);

    drain(10);
    if (shadow.errors == 0 && shadow.due_reports.size() == 0) begin
      $display("PASS dual_rotary_encoder_keypad_unit");
    end else begin
      $display("FAIL dual_rotary_encoder_keypad_unit");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/drek_pkg.sv
design/drek_knob_lane.sv
design/drek_push_lane.sv
design/drek_report_merge.sv
design/dual_rotary_encoder_keypad_unit.sv
design/drek_checker.sv
sim/dual_rotary_encoder_keypad_unit_tb.sv
